// ===== hdl/rco_pkg.sv =====
// Shared widths, codes and the queue entry type for the ray-circle observation time block.
// Depends on nothing; every other file uses it.
package rco_pkg;

  localparam int unsigned PosW        = 20;
  localparam int unsigned VelW        = 16;
  localparam int unsigned RadW        = 16;
  localparam int unsigned DiffW       = PosW + 1;
  localparam int unsigned ProdW       = DiffW + VelW;
  localparam int unsigned HW          = ProdW + 1;
  localparam int unsigned HabsW       = HW - 1;
  localparam int unsigned AW          = 2 * VelW;
  localparam int unsigned Sq2W        = 2 * DiffW;
  localparam int unsigned R2W         = 2 * RadW;
  localparam int unsigned HLoW        = 32;
  localparam int unsigned HHiW        = HabsW - HLoW;
  localparam int unsigned DW          = 75;
  localparam int unsigned FracBits    = 14;
  localparam int unsigned RootW       = 53;
  localparam int unsigned XW          = 2 * RootW;
  localparam int unsigned NumW        = RootW;
  localparam int unsigned TimeW       = 32;
  localparam int unsigned QueueDepth  = 4;
  localparam logic [TimeW-1:0] StationaryTicks = TimeW'(10240);
  localparam logic [TimeW-1:0] TimeMax         = '1;
  localparam logic [RadW-1:0]  RadiusReset     = RadW'(4000);

  typedef enum logic [1:0] {
    KIND_ZERO,
    KIND_FIXED,
    KIND_CALC
  } kind_e;

  typedef struct packed {
    logic [DW-1:0]    disc;
    logic [HabsW-1:0] habs;
    logic             hneg;
    logic [AW-1:0]    a;
    kind_e            kind;
  } job_t;

endpackage

// ===== hdl/rco_if.sv =====
// Handshake channel interfaces: input items, result items and the radius write port.
// Depends on rco_pkg for field widths.
interface rco_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [rco_pkg::PosW-1:0]   target_x;
  logic signed [rco_pkg::PosW-1:0]   target_y;
  logic signed [rco_pkg::PosW-1:0]   vehicle_x;
  logic signed [rco_pkg::PosW-1:0]   vehicle_y;
  logic signed [rco_pkg::VelW-1:0]   vehicle_vx;
  logic signed [rco_pkg::VelW-1:0]   vehicle_vy;
  modport source (output valid, target_x, target_y, vehicle_x, vehicle_y,
                  vehicle_vx, vehicle_vy, input ready);
  modport sink (input valid, target_x, target_y, vehicle_x, vehicle_y,
                vehicle_vx, vehicle_vy, output ready);
endinterface

interface rco_out_if;
  logic                         valid;
  logic                         ready;
  logic [rco_pkg::TimeW-1:0]    obs_time;
  logic                         in_view;
  modport source (output valid, obs_time, in_view, input ready);
  modport sink (input valid, obs_time, in_view, output ready);
endinterface

interface rco_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [rco_pkg::RadW-1:0]     data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== hdl/rco_front.sv =====
// Front pipeline: takes items, forms the quadratic terms and classifies each item.
// Holds the view radius register. Depends on rco_pkg and rco_if.
module rco_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  rco_in_if.sink        in_i,
  rco_cfg_if.sink       cfg_i,
  input  logic          full_i,
  output logic          push_o,
  output rco_pkg::job_t job_o
);
  import rco_pkg::*;

  logic [RadW-1:0] radius_q;
  logic v1_q, v2_q, v3_q, v4_q;
  logic en;

  logic signed [DiffW-1:0] dx_q, dy_q;
  logic signed [VelW-1:0]  vx_q, vy_q;

  logic signed [ProdW-1:0] hx_c, hy_c;
  logic signed [AW-1:0]    ax_c, ay_c;
  logic signed [Sq2W-1:0]  dx2_c, dy2_c;
  logic signed [ProdW-1:0] hx_q, hy_q;
  logic [AW-1:0]           ax_q, ay_q;
  logic [Sq2W-1:0]         dx2_q, dy2_q;
  logic [R2W-1:0]          r2_q;

  logic signed [HW-1:0] h_c;
  logic [AW-1:0]        a_c;
  logic [Sq2W-1:0]      dist2_c;
  logic                 lt_c, eq_c;
  kind_e                kind_c;
  logic [HabsW-1:0]     habs_c;
  logic [R2W-1:0]       negc_c;

  logic [HabsW-1:0] habs_q;
  logic             hneg_q;
  logic [AW-1:0]    a_q;
  logic [R2W-1:0]   negc_q;
  kind_e            kind_q;

  logic [2*HLoW-1:0]      pll_q;
  logic [HHiW+HLoW-1:0]   phl_q;
  logic [2*HHiW-1:0]      phh_q;
  logic [AW+R2W-1:0]      pan_q;
  logic [HabsW-1:0]       habs4_q;
  logic                   hneg4_q;
  logic [AW-1:0]          a4_q;
  kind_e                  kind4_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RadiusReset;
    end else if (cfg_i.valid) begin
      radius_q <= cfg_i.data;
    end
  end

  assign en         = !v4_q || !full_i;
  assign in_i.ready = en;
  assign push_o     = v4_q && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  assign hx_c  = dx_q * vx_q;
  assign hy_c  = dy_q * vy_q;
  assign ax_c  = vx_q * vx_q;
  assign ay_c  = vy_q * vy_q;
  assign dx2_c = dx_q * dx_q;
  assign dy2_c = dy_q * dy_q;

  assign h_c     = HW'(hx_q) + HW'(hy_q);
  assign a_c     = ax_q + ay_q;
  assign dist2_c = dx2_q + dy2_q;
  assign lt_c    = dist2_c < Sq2W'(r2_q);
  assign eq_c    = dist2_c == Sq2W'(r2_q);
  assign habs_c  = h_c[HW-1] ? HabsW'(-h_c) : HabsW'(h_c);
  assign negc_c  = r2_q - dist2_c[R2W-1:0];

  always_comb begin
    if (a_c == '0) begin
      kind_c = lt_c ? KIND_FIXED : KIND_ZERO;
    end else if (lt_c || (eq_c && h_c[HW-1])) begin
      kind_c = KIND_CALC;
    end else begin
      kind_c = KIND_ZERO;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q    <= DiffW'(in_i.vehicle_x) - DiffW'(in_i.target_x);
      dy_q    <= DiffW'(in_i.vehicle_y) - DiffW'(in_i.target_y);
      vx_q    <= in_i.vehicle_vx;
      vy_q    <= in_i.vehicle_vy;
      hx_q    <= hx_c;
      hy_q    <= hy_c;
      ax_q    <= ax_c;
      ay_q    <= ay_c;
      dx2_q   <= dx2_c;
      dy2_q   <= dy2_c;
      r2_q    <= radius_q * radius_q;
      habs_q  <= habs_c;
      hneg_q  <= h_c[HW-1];
      a_q     <= a_c;
      negc_q  <= negc_c;
      kind_q  <= kind_c;
      pll_q   <= habs_q[HLoW-1:0] * habs_q[HLoW-1:0];
      phl_q   <= habs_q[HabsW-1:HLoW] * habs_q[HLoW-1:0];
      phh_q   <= habs_q[HabsW-1:HLoW] * habs_q[HabsW-1:HLoW];
      pan_q   <= a_q * negc_q;
      habs4_q <= habs_q;
      hneg4_q <= hneg_q;
      a4_q    <= a_q;
      kind4_q <= kind_q;
    end
  end

  always_comb begin
    job_o.disc = DW'(pll_q) + (DW'(phl_q) << (HLoW + 1)) + (DW'(phh_q) << (2 * HLoW))
               + DW'(pan_q);
    job_o.habs = habs4_q;
    job_o.hneg = hneg4_q;
    job_o.a    = a4_q;
    job_o.kind = kind4_q;
  end

endmodule

// ===== hdl/rco_queue.sv =====
// Short queue of classified items between the front and back pipelines.
// Depends on rco_pkg.
module rco_queue #(
  parameter int unsigned Depth = rco_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rco_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output rco_pkg::job_t job_o
);
  import rco_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + CntW'(push_i) - CntW'(pop_i);
    end
  end

endmodule

// ===== hdl/rco_back.sv =====
// Back pipeline: one square root bit and one quotient bit per stage, then saturation.
// Drives the result channel through an output register. Depends on rco_pkg and rco_if.
module rco_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  rco_pkg::job_t job_i,
  output logic          pop_o,
  rco_out_if.source     out_o
);
  import rco_pkg::*;

  logic en;

  logic             sv_q    [RootW+1];
  logic [XW-1:0]    srem_q  [RootW+1];
  logic [RootW-1:0] sroot_q [RootW+1];
  logic [HabsW-1:0] shabs_q [RootW+1];
  logic             shneg_q [RootW+1];
  logic [AW-1:0]    sa_q    [RootW+1];
  kind_e            skind_q [RootW+1];

  logic             dv_q    [NumW+1];
  logic [AW-1:0]    drem_q  [NumW+1];
  logic [NumW-1:0]  dnum_q  [NumW+1];
  logic [NumW-1:0]  dquo_q  [NumW+1];
  logic [AW-1:0]    da_q    [NumW+1];
  kind_e            dkind_q [NumW+1];

  logic [NumW-1:0]  hs_c, num_c;
  logic [NumW-1:0]  quo_c;
  logic [TimeW-1:0] time_c;

  logic             out_v_q;
  logic [TimeW-1:0] out_time_q;
  logic             out_view_q;

  assign en    = !out_v_q || out_o.ready;
  assign pop_o = en && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q[0] <= 1'b0;
    end else if (en) begin
      sv_q[0] <= !empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      srem_q[0]  <= XW'(job_i.disc) << (2 * FracBits);
      sroot_q[0] <= '0;
      shabs_q[0] <= job_i.habs;
      shneg_q[0] <= job_i.hneg;
      sa_q[0]    <= job_i.a;
      skind_q[0] <= job_i.kind;
    end
  end

  for (genvar j = 0; j < RootW; j++) begin : g_sqrt
    localparam int unsigned Bit = RootW - 1 - j;
    logic [XW-1:0] trial;
    logic          take;
    assign trial = (XW'(sroot_q[j]) << (Bit + 1)) | (XW'(1) << (2 * Bit));
    assign take  = srem_q[j] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[j+1] <= 1'b0;
      end else if (en) begin
        sv_q[j+1] <= sv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        srem_q[j+1]  <= take ? srem_q[j] - trial : srem_q[j];
        sroot_q[j+1] <= take ? (sroot_q[j] | (RootW'(1) << Bit)) : sroot_q[j];
        shabs_q[j+1] <= shabs_q[j];
        shneg_q[j+1] <= shneg_q[j];
        sa_q[j+1]    <= sa_q[j];
        skind_q[j+1] <= skind_q[j];
      end
    end
  end

  assign hs_c  = NumW'(shabs_q[RootW]) << FracBits;
  assign num_c = shneg_q[RootW] ? NumW'(sroot_q[RootW]) + hs_c
                                : NumW'(sroot_q[RootW]) - hs_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (en) begin
      dv_q[0] <= sv_q[RootW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      drem_q[0]  <= '0;
      dnum_q[0]  <= num_c;
      dquo_q[0]  <= '0;
      da_q[0]    <= sa_q[RootW];
      dkind_q[0] <= skind_q[RootW];
    end
  end

  for (genvar j = 0; j < NumW; j++) begin : g_div
    localparam int unsigned Bit = NumW - 1 - j;
    logic [AW:0] part;
    logic        take;
    assign part = {drem_q[j], dnum_q[j][Bit]};
    assign take = part >= {1'b0, da_q[j]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j+1] <= 1'b0;
      end else if (en) begin
        dv_q[j+1] <= dv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        drem_q[j+1]  <= take ? AW'(part - {1'b0, da_q[j]}) : AW'(part);
        dnum_q[j+1]  <= dnum_q[j];
        dquo_q[j+1]  <= take ? (dquo_q[j] | (NumW'(1) << Bit)) : dquo_q[j];
        da_q[j+1]    <= da_q[j];
        dkind_q[j+1] <= dkind_q[j];
      end
    end
  end

  assign quo_c = dquo_q[NumW];

  always_comb begin
    if (dkind_q[NumW] == KIND_FIXED) begin
      time_c = StationaryTicks;
    end else if (dkind_q[NumW] == KIND_CALC) begin
      time_c = (quo_c[NumW-1:TimeW] != '0) ? TimeMax : quo_c[TimeW-1:0];
    end else begin
      time_c = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_q[NumW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_time_q <= time_c;
      out_view_q <= time_c != '0;
    end
  end

  assign out_o.valid    = out_v_q;
  assign out_o.obs_time = out_time_q;
  assign out_o.in_view  = out_view_q;

endmodule

// ===== hdl/ray_circle_observation_time.sv =====
// Top level of the ray-circle observation time block.
// Ties front pipeline, queue and back pipeline together. Depends on rco_pkg, rco_if and the
// rco_front, rco_queue and rco_back modules.
//
// Usage:
//   in_i  : one item per handshake: target and vehicle position, vehicle velocity.
//   out_o : one result per item, in order: obs_time (1/1024 s, saturating) and in_view.
//   cfg_i : writes the view radius (1/16 m); write only while no item is in flight.
//   Throughput: one item per cycle, sustained while out_o.ready stays high.
//   Path: 4 front stages, the queue register, a load register and 53 square root stages
//   (one root bit each), a load register and 53 divider stages (one quotient bit each) and
//   the output register.
//   Reset: radius returns to 4000, queue and all stage valid flags clear; ready comes up at
//   once, no clearing pass.
//   Receiver stall: the back pipeline holds, the queue fills, then the front holds and
//   in_i.ready drops. Input is taken again as soon as the queue has room.
module ray_circle_observation_time #(
  parameter int unsigned QueueDepth = rco_pkg::QueueDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  rco_in_if.sink   in_i,
  rco_cfg_if.sink  cfg_i,
  rco_out_if.source out_o
);
  import rco_pkg::*;

  logic push, full, pop, empty;
  job_t job_front, job_back;

  rco_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_i),
    .full_i (full),
    .push_o (push),
    .job_o  (job_front)
  );

  rco_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_front),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .job_o   (job_back)
  );

  rco_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .job_i   (job_back),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ===== tb/ray_circle_observation_time_tb.sv =====
// Testbench for ray_circle_observation_time: directed table and random vehicle-target
// items, checked per field against table times or an integer exit time predictor.
// Depends on rco_pkg, the rco_if interfaces and the RTL of the block.
module ray_circle_observation_time_tb;
  import rco_pkg::*;

  typedef struct {
    logic signed [PosW-1:0] tx;
    logic signed [PosW-1:0] ty;
    logic signed [PosW-1:0] px;
    logic signed [PosW-1:0] py;
    logic signed [VelW-1:0] vx;
    logic signed [VelW-1:0] vy;
  } query_t;

  typedef struct {
    logic [TimeW-1:0] obs_time;
    logic             in_view;
  } view_t;

  typedef struct {
    query_t           q;
    bit               typed;
    logic [TimeW-1:0] t;
  } row_t;

  logic clk_i;
  logic rst_ni;

  rco_in_if  in_if ();
  rco_out_if out_if ();
  rco_cfg_if cfg_if ();

  ray_circle_observation_time i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .cfg_i (cfg_if),
    .out_o (out_if)
  );

  view_t            pending_views[$];
  row_t             stim_table[$];
  logic [RadW-1:0]  radius;
  int unsigned      mismatches;
  int unsigned      cycles;
  bit               calm;
  bit               hold_request;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic view_t exit_time(query_t q, logic [RadW-1:0] r);
    longint      dx, dy, h;
    logic [127:0] a, dist2, r2, habs, negc, disc, root, cand, num, t;
    view_t       v;
    int          b;
    dx    = longint'(q.px) - longint'(q.tx);
    dy    = longint'(q.py) - longint'(q.ty);
    h     = dx * longint'(q.vx) + dy * longint'(q.vy);
    a     = 128'(longint'(q.vx) * longint'(q.vx) + longint'(q.vy) * longint'(q.vy));
    dist2 = 128'(dx * dx + dy * dy);
    r2    = 128'(r) * 128'(r);
    t     = '0;
    if (a == 0) begin
      t = (dist2 < r2) ? 128'(StationaryTicks) : '0;
    end else if (dist2 < r2 || (dist2 == r2 && h < 0)) begin
      habs = (h < 0) ? 128'(-h) : 128'(h);
      negc = r2 - dist2;
      disc = (habs * habs + a * negc) << (2 * FracBits);
      root = '0;
      for (b = RootW - 1; b >= 0; b--) begin
        cand = root | (128'(1) << b);
        if (cand * cand <= disc) root = cand;
      end
      num = (h < 0) ? root + (habs << FracBits) : root - (habs << FracBits);
      t   = num / a;
      if (t > 128'(TimeMax)) t = 128'(TimeMax);
    end
    v.obs_time = t[TimeW-1:0];
    v.in_view  = (t != 0);
    return v;
  endfunction

  function automatic query_t mk(int tx, int ty, int px, int py, int vx, int vy);
    query_t q;
    q.tx = PosW'(tx); q.ty = PosW'(ty); q.px = PosW'(px); q.py = PosW'(py);
    q.vx = VelW'(vx); q.vy = VelW'(vy);
    return q;
  endfunction

  function automatic void add_row(query_t q, bit typed, logic [TimeW-1:0] t);
    row_t r;
    r.q = q; r.typed = typed; r.t = t;
    stim_table.insert(stim_table.size(), r);
  endfunction

  function automatic query_t random_query(logic [RadW-1:0] r);
    query_t q;
    int     span, dx, dy;
    if ($urandom_range(0, 9) < 7) begin
      span  = int'(r) + 16;
      dx    = $urandom_range(0, 2 * span) - span;
      dy    = $urandom_range(0, 2 * span) - span;
      q.px  = PosW'($urandom_range(0, 2 * 393216) - 393216);
      q.py  = PosW'($urandom_range(0, 2 * 393216) - 393216);
      q.tx  = PosW'(q.px - dx);
      q.ty  = PosW'(q.py - dy);
      q.vx  = $signed(16'($urandom)) >>> $urandom_range(0, 15);
      q.vy  = $signed(16'($urandom)) >>> $urandom_range(0, 15);
      if ($urandom_range(0, 19) == 0) begin
        q.vx = '0;
        q.vy = '0;
      end
    end else begin
      q.tx = PosW'($urandom); q.ty = PosW'($urandom);
      q.px = PosW'($urandom); q.py = PosW'($urandom);
      q.vx = VelW'($urandom); q.vy = VelW'($urandom);
    end
    return q;
  endfunction

  task automatic send(query_t q, bit typed, logic [TimeW-1:0] t);
    view_t v;
    int    gap;
    in_if.valid      <= 1'b1;
    in_if.target_x   <= q.tx;
    in_if.target_y   <= q.ty;
    in_if.vehicle_x  <= q.px;
    in_if.vehicle_y  <= q.py;
    in_if.vehicle_vx <= q.vx;
    in_if.vehicle_vy <= q.vy;
    do @(posedge clk_i); while (!in_if.ready);
    v = exit_time(q, radius);
    if (typed) begin
      v.obs_time = t;
      v.in_view  = (t != 0);
    end
    pending_views.insert(pending_views.size(), v);
    gap = 0;
    if (!calm) begin
      case ($urandom_range(0, 9))
        0, 1, 2: gap = $urandom_range(1, 3);
        3:       gap = $urandom_range(10, 40);
        default: gap = 0;
      endcase
    end
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    while (pending_views.size() != 0) @(posedge clk_i);
    repeat (130) @(posedge clk_i);
  endtask

  task automatic write_radius(logic [RadW-1:0] r);
    in_if.valid  <= 1'b0;
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= r;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    radius = r;
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : receive
    view_t       v;
    int unsigned hold;
    bit          pressed;
    hold    = 0;
    pressed = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        if (pending_views.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected item obs_time=%0d", out_if.obs_time);
        end else begin
          v = pending_views.pop_front();
          if (out_if.obs_time !== v.obs_time || out_if.in_view !== v.in_view) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected obs_time=%0d in_view=%0d, got %0d %0d",
                       v.obs_time, v.in_view, out_if.obs_time, out_if.in_view);
          end
        end
      end
      if (hold_request && !pressed) begin
        pressed = 1;
        hold    = 600;
      end else if (hold == 0 && !calm) begin
        case ($urandom_range(0, 19))
          0, 1, 2: hold = $urandom_range(1, 3);
          3:       hold = $urandom_range(10, 40);
          default: hold = 0;
        endcase
      end
      if (hold > 0) begin
        out_if.ready <= 1'b0;
        hold--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [RadW-1:0] radii[6];
    int              p, i;
    mismatches   = 0;
    calm         = 0;
    hold_request = 0;
    radius       = RadiusReset;
    rst_ni       <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.target_x <= '0; in_if.target_y <= '0;
    in_if.vehicle_x <= '0; in_if.vehicle_y <= '0;
    in_if.vehicle_vx <= '0; in_if.vehicle_vy <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(mk(0, 0, 0, 0, 0, 0), 1, StationaryTicks);
    add_row(mk(10, -7, 0, 0, 0, 0), 1, StationaryTicks);
    add_row(mk(0, 0, 4000, 0, 0, 0), 1, '0);
    add_row(mk(524287, 524287, -524288, -524288, 32767, 32767), 1, '0);
    add_row(mk(0, 0, 4000, 0, -256, 0), 1, 32'd512000);
    add_row(mk(0, 0, 4000, 0, 256, 0), 1, '0);
    add_row(mk(0, 0, 4000, 0, 0, 256), 1, '0);
    add_row(mk(0, 0, 4001, 0, -256, 0), 1, '0);
    add_row(mk(0, 0, 3999, 0, 32767, 0), 0, '0);
    add_row(mk(5, 5, 5, 5, -32768, -32768), 0, '0);
    add_row(mk(0, 0, -3999, 0, 1, 0), 0, '0);
    add_row(mk(0, 0, 0, 3999, 0, -1), 0, '0);
    add_row(mk(-524288, -524288, -524288, -524288, 32767, 32767), 0, '0);
    add_row(mk(524287, 524287, 524287, 524287, -32768, 32767), 0, '0);
    add_row(mk(-2828, 2828, 0, 0, 100, -100), 0, '0);
    foreach (stim_table[k]) send(stim_table[k].q, stim_table[k].typed, stim_table[k].t);

    radii[0] = RadiusReset;
    radii[1] = '0;
    radii[2] = '1;
    radii[3] = RadW'(1);
    radii[4] = RadW'($urandom_range(1, 65534));
    radii[5] = RadW'($urandom_range(1, 8000));
    for (p = 0; p < 6; p++) begin
      write_radius(radii[p]);
      calm = (p == 3);
      if (p == 1) hold_request = 1;
      for (i = 0; i < 160; i++) send(random_query(radius), 0, '0);
    end

    in_if.valid <= 1'b0;
    drain();
    if (mismatches == 0 && pending_views.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
